// ===== hw/rtl/plagc_pkg.sv =====
package plagc_pkg;

  // Sample and arithmetic widths
  localparam int SAMPLE_BITS = 16;
  localparam int GAIN_W      = 17;
  localparam int COEF_W      = 16;
  localparam int LEVEL_W     = 15;
  localparam int FRAC_W      = 16;

  localparam logic [GAIN_W-1:0] UNITY = GAIN_W'(1) << FRAC_W;

  // Restoring divider: (level << SAMPLE_BITS) / |x|, one quotient bit per cycle
  localparam int DIVD_W    = LEVEL_W + SAMPLE_BITS;
  localparam int DIV_STEPS = DIVD_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  // Shared multiplier
  localparam int MUL_A_W = (SAMPLE_BITS > GAIN_W) ? SAMPLE_BITS : GAIN_W;
  localparam int PROD_W  = MUL_A_W + GAIN_W;
  localparam int ACC_W   = PROD_W + 1;
  localparam logic [ACC_W-1:0] HALF = ACC_W'(1) << (FRAC_W - 1);

  // Register port
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  typedef enum logic [1:0] {
    REG_BYPASS  = 2'd0,
    REG_LEVEL   = 2'd1,
    REG_ATTACK  = 2'd2,
    REG_RELEASE = 2'd3
  } reg_idx_e;

  localparam logic [LEVEL_W-1:0] LEVEL_RST   = LEVEL_W'(2320);
  localparam logic [COEF_W-1:0]  ATTACK_RST  = COEF_W'(65400);
  localparam logic [COEF_W-1:0]  RELEASE_RST = COEF_W'(65522);

  typedef struct packed {
    logic               bypass;
    logic [LEVEL_W-1:0] target_level;
    logic [COEF_W-1:0]  attack_coef;
    logic [COEF_W-1:0]  release_coef;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL_OLD,
    ST_MUL_NEW,
    ST_ROUND,
    ST_MUL_OUT,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic load;
    logic div_step;
    logic mul_old;
    logic mul_new;
    logic round;
    logic mul_out;
    logic emit;
  } cmd_t;

endpackage

// ===== hw/rtl/plagc_if.sv =====
interface plagc_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [plagc_pkg::SAMPLE_BITS-1:0] sample;
  logic                                  block_start;

  modport source (output valid, sample, block_start, input ready);
  modport sink (input valid, sample, block_start, output ready);
endinterface

interface plagc_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [plagc_pkg::SAMPLE_BITS-1:0] out_sample;
  logic [plagc_pkg::GAIN_W-1:0]          gain;

  modport source (output valid, out_sample, gain, input ready);
  modport sink (input valid, out_sample, gain, output ready);
endinterface

// ===== hw/rtl/peak_limiter_attack_release_agc_top.sv =====
// Channel  Dir  Payload                            Handshake
// req_i    in   sample (s16), block_start (1)     valid/ready
// rsp_o    out  out_sample (s16), gain (u17 Q1.16) valid/ready
// APB      in   bypass, target_level, attack, release at 0x0/0x4/0x8/0xC
//
// An item is accepted, then runs 31 divider steps (one quotient bit each, from the
// restoring divider), then the old-gain, new-target, rounding and output steps (all but
// rounding on the shared multiplier), then the result load. Bypass items skip to the load.
// Reset is asynchronous, active low; it restores register defaults and unity gain.
// A stalled output holds the result register; a new request is still taken
// and waits in the last step until the register is free.
module peak_limiter_attack_release_agc_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  plagc_in_if.sink                      req_i,
  plagc_out_if.source                   rsp_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [plagc_pkg::ADDR_W-1:0]  paddr,
  input  logic [plagc_pkg::DATA_W-1:0]  pwdata,
  output logic [plagc_pkg::DATA_W-1:0]  prdata,
  output logic                          pready
);

  plagc_pkg::cfg_t cfg;
  plagc_pkg::cmd_t cmd;

  plagc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  plagc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .bypass_i    (cfg.bypass),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .cmd_o       (cmd)
  );

  plagc_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .cmd_i         (cmd),
    .sample_i      (req_i.sample),
    .block_start_i (req_i.block_start),
    .out_sample_o  (rsp_o.out_sample),
    .gain_o        (rsp_o.gain)
  );

endmodule

// ===== hw/rtl/plagc_regs.sv =====
module plagc_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [plagc_pkg::ADDR_W-1:0]  paddr,
  input  logic [plagc_pkg::DATA_W-1:0]  pwdata,
  output logic [plagc_pkg::DATA_W-1:0]  prdata,
  output logic                          pready,
  output plagc_pkg::cfg_t               cfg_o
);

  plagc_pkg::cfg_t     cfg_q, cfg_d;
  plagc_pkg::reg_idx_e idx;
  logic                wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = plagc_pkg::reg_idx_e'(paddr[plagc_pkg::ADDR_W-1:2]);

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        plagc_pkg::REG_BYPASS:  cfg_d.bypass       = pwdata[0];
        plagc_pkg::REG_LEVEL:   cfg_d.target_level = pwdata[plagc_pkg::LEVEL_W-1:0];
        plagc_pkg::REG_ATTACK:  cfg_d.attack_coef  = pwdata[plagc_pkg::COEF_W-1:0];
        plagc_pkg::REG_RELEASE: cfg_d.release_coef = pwdata[plagc_pkg::COEF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      plagc_pkg::REG_BYPASS:  prdata = plagc_pkg::DATA_W'(cfg_q.bypass);
      plagc_pkg::REG_LEVEL:   prdata = plagc_pkg::DATA_W'(cfg_q.target_level);
      plagc_pkg::REG_ATTACK:  prdata = plagc_pkg::DATA_W'(cfg_q.attack_coef);
      plagc_pkg::REG_RELEASE: prdata = plagc_pkg::DATA_W'(cfg_q.release_coef);
      default:                prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bypass       <= 1'b0;
      cfg_q.target_level <= plagc_pkg::LEVEL_RST;
      cfg_q.attack_coef  <= plagc_pkg::ATTACK_RST;
      cfg_q.release_coef <= plagc_pkg::RELEASE_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hw/rtl/plagc_ctrl.sv =====
module plagc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              bypass_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output plagc_pkg::cmd_t   cmd_o
);

  plagc_pkg::state_e           state_q, state_d;
  logic [plagc_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic                        out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    // drop the result once the sink takes it
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      plagc_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = bypass_i ? plagc_pkg::ST_EMIT : plagc_pkg::ST_DIV;
        end
      end
      plagc_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == plagc_pkg::CNT_W'(plagc_pkg::DIV_STEPS - 1)) begin
          state_d = plagc_pkg::ST_MUL_OLD;
        end
      end
      plagc_pkg::ST_MUL_OLD: begin
        cmd_o.mul_old = 1'b1;
        state_d       = plagc_pkg::ST_MUL_NEW;
      end
      plagc_pkg::ST_MUL_NEW: begin
        cmd_o.mul_new = 1'b1;
        state_d       = plagc_pkg::ST_ROUND;
      end
      plagc_pkg::ST_ROUND: begin
        cmd_o.round = 1'b1;
        state_d     = plagc_pkg::ST_MUL_OUT;
      end
      plagc_pkg::ST_MUL_OUT: begin
        cmd_o.mul_out = 1'b1;
        state_d       = plagc_pkg::ST_EMIT;
      end
      plagc_pkg::ST_EMIT: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.emit  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = plagc_pkg::ST_IDLE;
        end
      end
      default: state_d = plagc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= plagc_pkg::ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten before it was taken");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == plagc_pkg::ST_DIV) |->
      (cnt_q <= plagc_pkg::CNT_W'(plagc_pkg::DIV_STEPS - 1)))
    else $error("divider step count out of range");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q != plagc_pkg::ST_IDLE))
    else $error("accepted request did not start processing");

endmodule

// ===== hw/rtl/plagc_dp.sv =====
module plagc_dp (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  plagc_pkg::cfg_t                          cfg_i,
  input  plagc_pkg::cmd_t                          cmd_i,
  input  logic signed [plagc_pkg::SAMPLE_BITS-1:0] sample_i,
  input  logic                                     block_start_i,
  output logic signed [plagc_pkg::SAMPLE_BITS-1:0] out_sample_o,
  output logic [plagc_pkg::GAIN_W-1:0]             gain_o
);

  localparam int SB   = plagc_pkg::SAMPLE_BITS;
  localparam int GW   = plagc_pkg::GAIN_W;
  localparam int FW   = plagc_pkg::FRAC_W;
  localparam int DW   = plagc_pkg::DIVD_W;
  localparam int AW   = plagc_pkg::ACC_W;
  localparam int HI_W = AW - FW;

  logic [SB-1:0]  raw_q, mag_q, mag_in;
  logic           neg_q;
  logic [GW-1:0]  gain_q;
  logic [DW-1:0]  dq_q;
  logic [SB-1:0]  rem_q;
  logic [SB:0]    rem_sh, rem_sub;
  logic           rem_ge;
  logic [GW-1:0]  tgt, tgt_q;
  logic [plagc_pkg::COEF_W-1:0] coef_sel, coef_q;
  logic [plagc_pkg::MUL_A_W-1:0] mul_a;
  logic [GW-1:0]  mul_b;
  logic [plagc_pkg::PROD_W-1:0] prod;
  logic [AW-1:0]  acc_q, acc_rnd;
  logic [HI_W-1:0] acc_hi;
  logic [GW-1:0]  gain_new;
  logic [SB-1:0]  ymag, yval;
  logic signed [SB-1:0] out_sample_q;
  logic [GW-1:0]  out_gain_q;

  assign mag_in = sample_i[SB-1] ? (~sample_i + 1'b1) : sample_i;

  // one quotient bit per step
  assign rem_sh  = {rem_q, dq_q[DW-1]};
  assign rem_ge  = rem_sh >= {1'b0, mag_q};
  assign rem_sub = rem_sh - {1'b0, mag_q};

  // |x| = 0 leaves an all-ones quotient, which saturates to unity
  assign tgt = (dq_q > DW'(plagc_pkg::UNITY)) ? plagc_pkg::UNITY : dq_q[GW-1:0];

  assign coef_sel = (tgt < gain_q) ? cfg_i.attack_coef : cfg_i.release_coef;

  always_comb begin
    mul_a = plagc_pkg::MUL_A_W'(mag_q);
    mul_b = gain_q;
    if (cmd_i.mul_old) begin
      mul_a = plagc_pkg::MUL_A_W'(coef_sel);
    end else if (cmd_i.mul_new) begin
      mul_a = plagc_pkg::MUL_A_W'(plagc_pkg::UNITY - GW'(coef_q));
      mul_b = tgt_q;
    end
  end

  assign prod = mul_a * mul_b;

  assign acc_rnd  = acc_q + plagc_pkg::HALF;
  assign acc_hi   = acc_rnd[AW-1:FW];
  assign gain_new = (acc_hi > HI_W'(plagc_pkg::UNITY)) ? plagc_pkg::UNITY : acc_hi[GW-1:0];
  assign ymag     = acc_hi[SB-1:0];
  assign yval     = neg_q ? (~ymag + 1'b1) : ymag;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= plagc_pkg::UNITY;
    end else if (cmd_i.load && block_start_i && !cfg_i.bypass) begin
      gain_q <= plagc_pkg::UNITY;
    end else if (cmd_i.round) begin
      gain_q <= gain_new;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      raw_q <= sample_i;
      neg_q <= sample_i[SB-1];
      mag_q <= mag_in;
      dq_q  <= {cfg_i.target_level, {SB{1'b0}}};
      rem_q <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q <= rem_ge ? rem_sub[SB-1:0] : rem_sh[SB-1:0];
      dq_q  <= {dq_q[DW-2:0], rem_ge};
    end
    if (cmd_i.mul_old) begin
      tgt_q  <= tgt;
      coef_q <= coef_sel;
      acc_q  <= AW'(prod);
    end
    if (cmd_i.mul_new) begin
      acc_q <= acc_q + AW'(prod);
    end
    if (cmd_i.mul_out) begin
      acc_q <= AW'(prod);
    end
    if (cmd_i.emit) begin
      out_sample_q <= cfg_i.bypass ? raw_q : yval;
      out_gain_q   <= cfg_i.bypass ? plagc_pkg::UNITY : gain_q;
    end
  end

  assign out_sample_o = out_sample_q;
  assign gain_o       = out_gain_q;

  a_gain_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gain_q <= plagc_pkg::UNITY)
    else $error("running gain above unity");

endmodule
